// ===== rtl/core/pgv_pkg.sv =====
// Shared types and constants of the pairwise gravity velocity update.
// Used by the square-root cells, the divider cells and the top level.
// No dependencies.
`timescale 1ns / 1ps

package pgv_pkg;

  localparam int unsigned RootW  = 34;   // bits of the distance, Q.8
  localparam int unsigned RemSqW = 68;   // square-root remainder
  localparam int unsigned SumW   = 66;   // dx^2 + dy^2
  localparam int unsigned NumW   = 104;  // mass * step * K * |diff|
  localparam int unsigned DvW    = 128;  // denominator, Q.24 shifted
  localparam int unsigned QW     = 42;   // quotient bits kept
  localparam int unsigned QSkip  = NumW - QW - 20;

  localparam logic [22:0]       GravK         = 23'd6442451;
  localparam logic [RootW-1:0]  NearLimit     = RootW'(5120);
  localparam logic [DvW-1:0]    NearDen       = DvW'(8000) << 48;
  localparam logic [QW-1:0]     QClamp        = QW'(1) << 40;
  localparam logic [15:0]       TimeStepReset = 16'd256;

  // Velocity and direction of one item, carried along the whole pipeline.
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               xpos;
    logic               xneg;
    logic               ypos;
    logic               yneg;
  } vel_t;

  typedef struct packed {
    vel_t              v;
    logic [NumW-1:0]   nx;
    logic [NumW-1:0]   ny;
    logic [RemSqW-1:0] rem;
    logic [RootW-1:0]  root;
  } sq_t;

  typedef struct packed {
    vel_t            v;
    logic [NumW-1:0] nx;
    logic [NumW-1:0] ny;
    logic [DvW-1:0]  dv;
    logic [DvW-1:0]  rx;
    logic [DvW-1:0]  ry;
    logic [QW-1:0]   qx;
    logic [QW-1:0]   qy;
    logic            bigx;
    logic            bigy;
  } dv_t;

endpackage

// ===== rtl/core/pgv_sqrt_cell.sv =====
// One cell of the square-root chain: settles one bit of the root.
// Depends on pgv_pkg.
`timescale 1ns / 1ps

module pgv_sqrt_cell #(
  parameter int unsigned Bit = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  pgv_pkg::sq_t  data_i,
  output logic          valid_o,
  output pgv_pkg::sq_t  data_o
);
  import pgv_pkg::*;

  logic              valid_q;
  sq_t               data_d, data_q;
  logic [RemSqW-1:0] trial;

  // Going from r to r + 2^Bit adds 2r*2^Bit + 2^(2*Bit) to the square.
  always_comb begin
    data_d = data_i;
    trial  = (RemSqW'(data_i.root) << (Bit + 1)) | (RemSqW'(1) << (2 * Bit));
    if (data_i.rem >= trial) begin
      data_d.rem  = data_i.rem - trial;
      data_d.root = data_i.root | (RootW'(1) << Bit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/pgv_div_cell.sv =====
// One cell of the divider chain: one restoring step for x and for y.
// Depends on pgv_pkg.
`timescale 1ns / 1ps

module pgv_div_cell #(
  parameter int unsigned Bit = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  pgv_pkg::dv_t  data_i,
  output logic          valid_o,
  output pgv_pkg::dv_t  data_o
);
  import pgv_pkg::*;

  logic           valid_q;
  dv_t            data_d, data_q;
  logic [DvW-1:0] remx, remy;

  always_comb begin
    data_d = data_i;
    remx   = {data_i.rx[DvW-2:0], data_i.nx[Bit]};
    remy   = {data_i.ry[DvW-2:0], data_i.ny[Bit]};
    data_d.rx = remx;
    data_d.ry = remy;
    if (remx >= data_i.dv) begin
      data_d.rx      = remx - data_i.dv;
      data_d.qx[Bit] = 1'b1;
    end
    if (remy >= data_i.dv) begin
      data_d.ry      = remy - data_i.dv;
      data_d.qy[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/pairwise_gravity_velocity_update.sv =====
// Top level of the pairwise gravity velocity update: front stages, the
// square-root and divider cell chains, the final sum and the skid stage.
// Depends on pgv_pkg, pgv_sqrt_cell and pgv_div_cell.
//
// Usage: each item on the slave stream carries one body's position and
// velocity and the position and mass of an attracting body; one result item
// per input item leaves on the master stream with the new velocity and a
// flag in tuser that is set when either component saturated. The user must
// write the timestep register through time_step_we_i / time_step_i only while
// the block is idle; the block itself does not enforce this. It resets to 1.0.
// Throughput is one item per cycle while the skid register is empty. Each item
// passes in order through five front stages, 34 square-root cells (one root
// bit each), three cube stages, one divider set-up stage, 42 divider cells
// (one quotient bit each, x and y side by side) and one output stage.
// Reset empties the pipeline. When the receiver stalls, the waiting result
// moves into a skid register in the same cycle an item is still accepted;
// after that the whole pipeline holds until the skid register is taken.
`timescale 1ns / 1ps

module pairwise_gravity_velocity_update (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         time_step_we_i,
  input  logic [15:0]  time_step_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // self_pos_x, self_pos_y, self_vel_x, self_vel_y, other_pos_x,
  // other_pos_y, other_mass, from the lowest bit up
  input  logic [223:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_vel_x, new_vel_y, from the lowest bit up
  output logic [63:0]  m_axis_tdata,
  // clipped
  output logic         m_axis_tuser
);
  import pgv_pkg::*;

  localparam logic signed [43:0] VelMax = 44'sd2147483647;
  localparam logic signed [43:0] VelMin = -44'sd2147483648;

  logic        en;
  logic [15:0] time_step_q;

  // The whole pipeline moves unless a result is parked in the skid register.
  logic sk_v_q;
  assign en            = !sk_v_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= TimeStepReset;
    end else if (time_step_we_i) begin
      time_step_q <= time_step_i;
    end
  end

  // Stage 1: differences, their magnitudes and directions.
  logic signed [32:0] dx, dy;
  logic        s1_v_q;
  vel_t        s1_vel_q;
  logic [32:0] s1_ax_q, s1_ay_q;
  logic [31:0] s1_mass_q;

  assign dx = {s_axis_tdata[31], s_axis_tdata[31:0]}
            - {s_axis_tdata[159], s_axis_tdata[159:128]};
  assign dy = {s_axis_tdata[63], s_axis_tdata[63:32]}
            - {s_axis_tdata[191], s_axis_tdata[191:160]};

  // Stage 2: squares and mass times timestep.
  logic        s2_v_q;
  vel_t        s2_vel_q;
  logic [32:0] s2_ax_q, s2_ay_q;
  logic [65:0] s2_sqx_q, s2_sqy_q;
  logic [47:0] s2_mt_q;

  // Stage 3: sum of squares and the gain factor.
  logic            s3_v_q;
  vel_t            s3_vel_q;
  logic [32:0]     s3_ax_q, s3_ay_q;
  logic [SumW-1:0] s3_s_q;
  logic [70:0]     s3_mk_q;

  // Stage 4: partial products of the numerators.
  logic            s4_v_q;
  vel_t            s4_vel_q;
  logic [SumW-1:0] s4_s_q;
  logic [68:0]     s4_pxl_q, s4_pyl_q;
  logic [67:0]     s4_pxh_q, s4_pyh_q;

  // Stage 5: numerators, and the start of the square-root chain.
  logic s5_v_q;
  sq_t  s5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= s_axis_tvalid;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_vel_q.vx   <= s_axis_tdata[95:64];
      s1_vel_q.vy   <= s_axis_tdata[127:96];
      s1_vel_q.xpos <= !dx[32] && (dx != 33'sd0);
      s1_vel_q.xneg <= dx[32];
      s1_vel_q.ypos <= !dy[32] && (dy != 33'sd0);
      s1_vel_q.yneg <= dy[32];
      s1_ax_q       <= dx[32] ? 33'(-dx) : 33'(dx);
      s1_ay_q       <= dy[32] ? 33'(-dy) : 33'(dy);
      s1_mass_q     <= s_axis_tdata[223:192];

      s2_vel_q <= s1_vel_q;
      s2_ax_q  <= s1_ax_q;
      s2_ay_q  <= s1_ay_q;
      s2_sqx_q <= 66'(s1_ax_q) * 66'(s1_ax_q);
      s2_sqy_q <= 66'(s1_ay_q) * 66'(s1_ay_q);
      s2_mt_q  <= 48'(s1_mass_q) * 48'(time_step_q);

      s3_vel_q <= s2_vel_q;
      s3_ax_q  <= s2_ax_q;
      s3_ay_q  <= s2_ay_q;
      s3_s_q   <= s2_sqx_q + s2_sqy_q;
      s3_mk_q  <= 71'(s2_mt_q) * 71'(GravK);

      s4_vel_q <= s3_vel_q;
      s4_s_q   <= s3_s_q;
      s4_pxl_q <= 69'(s3_mk_q[35:0]) * 69'(s3_ax_q);
      s4_pyl_q <= 69'(s3_mk_q[35:0]) * 69'(s3_ay_q);
      s4_pxh_q <= 68'(s3_mk_q[70:36]) * 68'(s3_ax_q);
      s4_pyh_q <= 68'(s3_mk_q[70:36]) * 68'(s3_ay_q);

      s5_q.v    <= s4_vel_q;
      s5_q.nx   <= (NumW'(s4_pxh_q) << 36) + NumW'(s4_pxl_q);
      s5_q.ny   <= (NumW'(s4_pyh_q) << 36) + NumW'(s4_pyl_q);
      s5_q.rem  <= RemSqW'(s4_s_q);
      s5_q.root <= '0;
    end
  end

  // Square-root chain, most significant root bit first.
  logic sq_valid [RootW+1];
  sq_t  sq_data  [RootW+1];

  assign sq_valid[0] = s5_v_q;
  assign sq_data[0]  = s5_q;

  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    pgv_sqrt_cell #(
      .Bit (RootW - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[k]),
      .data_i  (sq_data[k]),
      .valid_o (sq_valid[k+1]),
      .data_o  (sq_data[k+1])
    );
  end

  // Cube stages: d^2, two partial products of d^3, then the denominator.
  logic             c1_v_q, c2_v_q, c3_v_q, d0_v_q;
  vel_t             c1_vel_q, c2_vel_q, c3_vel_q;
  logic [NumW-1:0]  c1_nx_q, c1_ny_q, c2_nx_q, c2_ny_q, c3_nx_q, c3_ny_q;
  logic [RootW-1:0] c1_root_q, d_root;
  logic [67:0]      c1_dsq_q;
  logic             c1_near_q, c2_near_q;
  logic [66:0]      c2_pl_q, c2_ph_q;
  logic [DvW-1:0]   c3_dv_q;
  logic [100:0]     cube;
  dv_t              d0_q;
  logic [DvW-1:0]   d0_rx, d0_ry;

  assign d_root = sq_data[RootW].root;
  assign cube   = (101'(c2_ph_q) << 33) + 101'(c2_pl_q);
  assign d0_rx  = DvW'(c3_nx_q >> QW);
  assign d0_ry  = DvW'(c3_ny_q >> QW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_v_q <= 1'b0;
      c2_v_q <= 1'b0;
      c3_v_q <= 1'b0;
      d0_v_q <= 1'b0;
    end else if (en) begin
      c1_v_q <= sq_valid[RootW];
      c2_v_q <= c1_v_q;
      c3_v_q <= c2_v_q;
      d0_v_q <= c3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_vel_q  <= sq_data[RootW].v;
      c1_nx_q   <= sq_data[RootW].nx;
      c1_ny_q   <= sq_data[RootW].ny;
      c1_root_q <= d_root;
      c1_dsq_q  <= 68'(d_root) * 68'(d_root);
      c1_near_q <= d_root < NearLimit;

      c2_vel_q  <= c1_vel_q;
      c2_nx_q   <= c1_nx_q;
      c2_ny_q   <= c1_ny_q;
      c2_near_q <= c1_near_q;
      c2_pl_q   <= 67'(c1_dsq_q[32:0]) * 67'(c1_root_q);
      c2_ph_q   <= 67'(c1_dsq_q[65:33]) * 67'(c1_root_q);

      c3_vel_q <= c2_vel_q;
      c3_nx_q  <= c2_nx_q;
      c3_ny_q  <= c2_ny_q;
      c3_dv_q  <= c2_near_q ? NearDen : (DvW'(cube) << 24);

      // Quotient bits above those kept only matter for the clamp.
      d0_q.v    <= c3_vel_q;
      d0_q.nx   <= c3_nx_q;
      d0_q.ny   <= c3_ny_q;
      d0_q.dv   <= c3_dv_q;
      d0_q.rx   <= d0_rx;
      d0_q.ry   <= d0_ry;
      d0_q.qx   <= '0;
      d0_q.qy   <= '0;
      d0_q.bigx <= d0_rx >= c3_dv_q;
      d0_q.bigy <= d0_ry >= c3_dv_q;
    end
  end

  // Divider chain, most significant quotient bit first.
  logic dv_valid [QW+1];
  dv_t  dv_data  [QW+1];

  assign dv_valid[0] = d0_v_q;
  assign dv_data[0]  = d0_q;

  for (genvar k = 0; k < QW; k++) begin : g_div
    pgv_div_cell #(
      .Bit (QW - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_valid[k]),
      .data_i  (dv_data[k]),
      .valid_o (dv_valid[k+1]),
      .data_o  (dv_data[k+1])
    );
  end

  // Final stage: clamp the magnitude, apply it against the direction of the
  // difference and saturate to the velocity range.
  dv_t               fin;
  logic [QW-1:0]     qx, qy;
  logic signed [43:0] sumx, sumy, vxe, vye, qxe, qye;
  logic              clipx, clipy;
  logic [31:0]       outx, outy;
  logic              f_v_q, f_clip_q, sk_clip_q;
  logic [31:0]       f_x_q, f_y_q, sk_x_q, sk_y_q;

  assign fin = dv_data[QW];

  always_comb begin
    qx  = (fin.bigx || fin.qx > QClamp) ? QClamp : fin.qx;
    qy  = (fin.bigy || fin.qy > QClamp) ? QClamp : fin.qy;
    vxe = 44'(fin.v.vx);
    vye = 44'(fin.v.vy);
    qxe = $signed({2'b00, qx});
    qye = $signed({2'b00, qy});
    if (fin.v.xpos) begin
      sumx = vxe - qxe;
    end else if (fin.v.xneg) begin
      sumx = vxe + qxe;
    end else begin
      sumx = vxe;
    end
    if (fin.v.ypos) begin
      sumy = vye - qye;
    end else if (fin.v.yneg) begin
      sumy = vye + qye;
    end else begin
      sumy = vye;
    end
    clipx = 1'b1;
    clipy = 1'b1;
    if (sumx > VelMax) begin
      outx = 32'h7fff_ffff;
    end else if (sumx < VelMin) begin
      outx = 32'h8000_0000;
    end else begin
      outx  = sumx[31:0];
      clipx = 1'b0;
    end
    if (sumy > VelMax) begin
      outy = 32'h7fff_ffff;
    end else if (sumy < VelMin) begin
      outy = 32'h8000_0000;
    end else begin
      outy  = sumy[31:0];
      clipy = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q  <= 1'b0;
      sk_v_q <= 1'b0;
    end else begin
      if (en) begin
        f_v_q <= dv_valid[QW];
      end
      if (sk_v_q) begin
        if (m_axis_tready) begin
          sk_v_q <= 1'b0;
        end
      end else if (f_v_q && !m_axis_tready) begin
        sk_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_x_q    <= outx;
      f_y_q    <= outy;
      f_clip_q <= clipx || clipy;
    end
    if (!sk_v_q) begin
      sk_x_q    <= f_x_q;
      sk_y_q    <= f_y_q;
      sk_clip_q <= f_clip_q;
    end
  end

  assign m_axis_tvalid = sk_v_q || f_v_q;
  assign m_axis_tdata  = sk_v_q ? {sk_y_q, sk_x_q} : {f_y_q, f_x_q};
  assign m_axis_tuser  = sk_v_q ? sk_clip_q : f_clip_q;

endmodule
